// ===== rtl/core/fir_filter_edge_padded_defines.svh =====
// Assertion macros used by the checker module fep_check.
`ifndef FIR_FILTER_EDGE_PADDED_DEFINES_SVH
`define FIR_FILTER_EDGE_PADDED_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fep_pkg.sv =====
package fep_pkg;

	localparam int MAX_TAPS_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int VALUE_W         = 35;
	localparam int COEF_W          = 16;
	localparam int NUM_PAIRS       = 4;
	localparam int TCNT_W          = 4;
	localparam int CENTER_W        = 3;
	localparam int SEQ_W           = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 35;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_01   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_23   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_45   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_67   = 3'd7;

	typedef logic [NUM_PAIRS-1:0][2*COEF_W-1:0] coef_bank_t;

	typedef struct packed {
		logic head;
		logic last;
		logic err;
	} item_flags_t;

	function automatic logic [COEF_W-1:0] tap_sel(coef_bank_t bank, logic [2:0] idx);
		logic [2*COEF_W-1:0] pair;
		pair = bank[idx[2:1]];
		return idx[0] ? pair[2*COEF_W-1:COEF_W] : pair[COEF_W-1:0];
	endfunction

endpackage

// ===== rtl/core/fep_window.sv =====
module fep_window #(
	parameter int MAX_TAPS    = fep_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fep_pkg::SAMPLE_BITS_DEF,
	parameter int NW          = $clog2(MAX_TAPS + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	input  logic                                   list_end,
	input  logic [NW-1:0]                          n_eff,
	output logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]   win_s1,
	output logic                                   valid_s1,
	output fep_pkg::item_flags_t                   flags_s1,
	input  logic                                   ready_s1
);

	logic          accept;
	logic [NW-1:0] fill_q;
	logic [NW-1:0] fill_inc;
	logic          full;
	logic          head;

	assign in_ready = !valid_s1 || ready_s1;
	assign accept   = in_valid && in_ready;
	assign fill_inc = (fill_q == NW'(MAX_TAPS)) ? fill_q : fill_q + NW'(1);
	assign full     = fill_inc >= n_eff;
	assign head     = fill_inc == n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			fill_q   <= list_end ? '0 : fill_inc;
			valid_s1 <= full || list_end;
		end else if (ready_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// shift in every accepted sample; an item that closes no window and ends no list is not passed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_s1   <= '0;
			flags_s1 <= '0;
		end else if (accept) begin
			for (int i = 0; i < MAX_TAPS - 1; i++) begin
				win_s1[i] <= win_s1[i+1];
			end
			win_s1[MAX_TAPS-1] <= sample;
			flags_s1.head      <= head;
			flags_s1.last      <= list_end;
			flags_s1.err       <= !full;
		end
	end

endmodule

// ===== rtl/core/fep_mac.sv =====
module fep_mac #(
	parameter int MAX_TAPS    = fep_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fep_pkg::SAMPLE_BITS_DEF,
	parameter int NW          = $clog2(MAX_TAPS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_s1,
	input  logic                                 valid_s1,
	input  fep_pkg::item_flags_t                 flags_s1,
	output logic                                 ready_s1,
	input  fep_pkg::coef_bank_t                  coef,
	input  logic [NW-1:0]                        n_eff,
	output logic                                 valid_s3,
	output fep_pkg::item_flags_t                 flags_s3,
	output logic signed [fep_pkg::VALUE_W-1:0]   psum_lo_s3,
	output logic signed [fep_pkg::VALUE_W-1:0]   psum_hi_s3,
	input  logic                                 ready_s3
);

	localparam int VW   = fep_pkg::VALUE_W;
	localparam int CW   = fep_pkg::COEF_W;
	localparam int PW   = SAMPLE_BITS + CW;
	localparam int HALF = (MAX_TAPS + 1) / 2;

	logic [MAX_TAPS-1:0][CW-1:0] tap;
	logic signed [PW-1:0]        prod [MAX_TAPS];
	logic signed [VW-1:0]        prod_s2 [MAX_TAPS];
	logic signed [VW-1:0]        ps_lo;
	logic signed [VW-1:0]        ps_hi;
	fep_pkg::item_flags_t        flags_s2;
	logic                        valid_s2;
	logic                        adv2;
	logic                        adv3;

	assign adv3     = !valid_s3 || ready_s3;
	assign adv2     = !valid_s2 || adv3;
	assign ready_s1 = adv2;

	// oldest sample in use meets tap 0
	always_comb begin
		for (int j = 0; j < MAX_TAPS; j++) begin
			if (j + int'(n_eff) >= MAX_TAPS) begin
				tap[j] = fep_pkg::tap_sel(coef, 3'(j + int'(n_eff) - MAX_TAPS));
			end else begin
				tap[j] = '0;
			end
			prod[j] = $signed(win_s1[j]) * $signed(tap[j]);
		end
	end

	always_comb begin
		ps_lo = '0;
		ps_hi = '0;
		for (int j = 0; j < MAX_TAPS; j++) begin
			if (j < HALF) begin
				ps_lo = ps_lo + prod_s2[j];
			end else begin
				ps_hi = ps_hi + prod_s2[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int j = 0; j < MAX_TAPS; j++) begin
				prod_s2[j] <= VW'(prod[j]);
			end
			flags_s2 <= flags_s1;
		end
		if (adv3) begin
			psum_lo_s3 <= ps_lo;
			psum_hi_s3 <= ps_hi;
			flags_s3   <= flags_s2;
		end
	end

endmodule

// ===== rtl/core/fep_emit.sv =====
module fep_emit #(
	parameter int MAX_TAPS = fep_pkg::MAX_TAPS_DEF,
	parameter int NW       = $clog2(MAX_TAPS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s3,
	input  fep_pkg::item_flags_t                flags_s3,
	input  logic signed [fep_pkg::VALUE_W-1:0]  psum_lo_s3,
	input  logic signed [fep_pkg::VALUE_W-1:0]  psum_hi_s3,
	output logic                                ready_s3,
	input  logic [NW-1:0]                       n_eff,
	input  logic [fep_pkg::CENTER_W-1:0]        center_pos,
	input  logic                                pad_mode,
	input  logic signed [fep_pkg::VALUE_W-1:0]  pad_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fep_pkg::VALUE_W-1:0]  value,
	output logic                                status,
	output logic                                run_last
);

	localparam int SW = fep_pkg::SEQ_W;

	logic                               busy_q;
	logic [SW-1:0]                      idx_q;
	logic [SW-1:0]                      pre_q;
	logic [SW-1:0]                      lst_q;
	logic                               err_q;
	logic signed [fep_pkg::VALUE_W-1:0] sum_q;
	logic [SW-1:0]                      pre_d;
	logic [SW-1:0]                      lst_d;
	logic                               done;
	logic                               load;

	assign done     = busy_q && out_ready && (idx_q == lst_q);
	assign ready_s3 = !busy_q || done;
	assign load     = valid_s3 && ready_s3;

	always_comb begin
		int c_i;
		int n_i;
		int p_i;
		int t_i;
		c_i = int'(center_pos);
		n_i = int'(n_eff);
		p_i = flags_s3.head ? c_i : 0;
		t_i = (flags_s3.last && !flags_s3.err && (c_i + 1 < n_i)) ? n_i - c_i - 1 : 0;
		pre_d = SW'(p_i);
		lst_d = SW'(p_i + t_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (idx_q == lst_q) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pre_q <= pre_d;
			lst_q <= lst_d;
			err_q <= flags_s3.err;
			sum_q <= flags_s3.err ? '0 : psum_lo_s3 + psum_hi_s3;
		end
	end

	assign out_valid = busy_q;
	assign value     = (pad_mode && !err_q && (idx_q != pre_q)) ? pad_value : sum_q;
	assign status    = err_q;
	assign run_last  = idx_q == lst_q;

endmodule

// ===== rtl/core/fir_filter_edge_padded.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------
// input    | in_valid/in_ready   | sample, list_end
// output   | out_valid/out_ready | value, status, run_last
// config   | cfg_we              | cfg_addr, cfg_data
//
// One sample a cycle is taken while each sample gives at most one result and out_ready stays high.
// A sample that gives several results keeps the output sequencer busy for each result,
// so once the stages ahead are full the input stalls while those results drain.
// Reset clears the fill count, sample window and stage valids, and sets the config registers to their defaults.
// A stalled output backs up through the three stages into in_ready.
module fir_filter_edge_padded #(
	parameter int MAX_TAPS    = fep_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fep_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 list_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fep_pkg::VALUE_W-1:0]   value,
	output logic                                 status,
	output logic                                 run_last,
	input  logic                                 cfg_we,
	input  logic [fep_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [fep_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int NW = $clog2(MAX_TAPS + 1);

	logic [fep_pkg::TCNT_W-1:0]           tap_count_q;
	logic [fep_pkg::CENTER_W-1:0]         center_q;
	logic                                 pad_mode_q;
	logic signed [fep_pkg::VALUE_W-1:0]   pad_value_q;
	fep_pkg::coef_bank_t                  coef_q;
	logic [NW-1:0]                        n_eff;

	logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_s1;
	logic                                 valid_s1;
	logic                                 ready_s1;
	fep_pkg::item_flags_t                 flags_s1;
	logic                                 valid_s3;
	logic                                 ready_s3;
	fep_pkg::item_flags_t                 flags_s3;
	logic signed [fep_pkg::VALUE_W-1:0]   psum_lo_s3;
	logic signed [fep_pkg::VALUE_W-1:0]   psum_hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fep_pkg::TCNT_W'(1);
			center_q    <= '0;
			pad_mode_q  <= 1'b0;
			pad_value_q <= '0;
			coef_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fep_pkg::REG_TAP_COUNT: tap_count_q <= cfg_data[fep_pkg::TCNT_W-1:0];
				fep_pkg::REG_CENTER:    center_q    <= cfg_data[fep_pkg::CENTER_W-1:0];
				fep_pkg::REG_PAD_MODE:  pad_mode_q  <= cfg_data[0];
				fep_pkg::REG_PAD_VALUE: pad_value_q <= cfg_data[fep_pkg::VALUE_W-1:0];
				fep_pkg::REG_COEF_01:   coef_q[0]   <= cfg_data[31:0];
				fep_pkg::REG_COEF_23:   coef_q[1]   <= cfg_data[31:0];
				fep_pkg::REG_COEF_45:   coef_q[2]   <= cfg_data[31:0];
				fep_pkg::REG_COEF_67:   coef_q[3]   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// clamp tap count to 1..MAX_TAPS
	always_comb begin
		if (tap_count_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			n_eff = NW'(MAX_TAPS);
		end else begin
			n_eff = NW'(tap_count_q);
		end
	end

	fep_window #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.NW          (NW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.list_end (list_end),
		.n_eff    (n_eff),
		.win_s1   (win_s1),
		.valid_s1 (valid_s1),
		.flags_s1 (flags_s1),
		.ready_s1 (ready_s1)
	);

	fep_mac #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.NW          (NW)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_s1     (win_s1),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1),
		.ready_s1   (ready_s1),
		.coef       (coef_q),
		.n_eff      (n_eff),
		.valid_s3   (valid_s3),
		.flags_s3   (flags_s3),
		.psum_lo_s3 (psum_lo_s3),
		.psum_hi_s3 (psum_hi_s3),
		.ready_s3   (ready_s3)
	);

	fep_emit #(
		.MAX_TAPS (MAX_TAPS),
		.NW       (NW)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s3   (valid_s3),
		.flags_s3   (flags_s3),
		.psum_lo_s3 (psum_lo_s3),
		.psum_hi_s3 (psum_hi_s3),
		.ready_s3   (ready_s3),
		.n_eff      (n_eff),
		.center_pos (center_q),
		.pad_mode   (pad_mode_q),
		.pad_value  (pad_value_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.status     (status),
		.run_last   (run_last)
	);

endmodule

// ===== rtl/core/fep_check.sv =====
`include "fir_filter_edge_padded_defines.svh"

module fep_check #(
	parameter int SAMPLE_BITS = fep_pkg::SAMPLE_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic signed [SAMPLE_BITS-1:0]      sample,
	input logic                               list_end,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [fep_pkg::VALUE_W-1:0] value,
	input logic                               status,
	input logic                               run_last,
	input logic                               cfg_we,
	input logic [fep_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input logic [fep_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic in_xfer;
	logic cfg_seen;

	assign in_xfer  = in_valid && in_ready && (sample == sample) && (list_end == list_end);
	assign cfg_seen = cfg_we && (cfg_addr == cfg_addr) && (cfg_data == cfg_data);

	`FEP_ASSERT_NOW(a_err_single, out_valid && status, run_last, "error result must end its run")
	`FEP_ASSERT_NOW(a_err_zero, out_valid && status, value == '0, "error result must be zero")
	`FEP_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last && !cfg_seen, out_valid,
		"run broken before its last transfer")
	`FEP_ASSERT_NEXT(a_hold, out_valid && !out_ready && !cfg_seen && !in_xfer,
		out_valid && $stable(value) && $stable(run_last), "stalled result changed")

endmodule

bind fir_filter_edge_padded fep_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_fep_check (.*);
